/* rtl/sfdr_pkg.sv */
// ----------------------------------------------------------------------------
// sfdr_pkg
// Shared widths, codes and types of the screen frame delta recorder.
// ----------------------------------------------------------------------------
package sfdr_pkg;

  localparam int unsigned MAX_CELLS_DEF = 4096;

  localparam int unsigned CELL_W    = 32;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned REC_IDX_W = 13;
  localparam int unsigned FRAME_W   = 32;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CFG_W-1:0]  CELLS_IN_USE_RST = 13'd1921;
  localparam logic [CELL_W-1:0] WORD_NEVER_SET   = 32'hFFFF_FFFF;

  // Register index, taken from paddr[2]
  localparam logic REG_CELLS_IN_USE = 1'b0;

  typedef enum logic {
    FUNC_CELL = 1'b0,
    FUNC_EOF  = 1'b1
  } func_e;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

endpackage

/* rtl/sfdr_cell_mem.sv */
// ----------------------------------------------------------------------------
// sfdr_cell_mem
// Previous-value store for screen cells: one write and one registered read
// per cycle, a clearing sweep to all ones after reset, and write-to-read
// forwarding for a write landing on the entry being read.
// ----------------------------------------------------------------------------
module sfdr_cell_mem #(
  parameter int unsigned MAX_CELLS = sfdr_pkg::MAX_CELLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [sfdr_pkg::IDX_W-1:0]     rd_index_i,
  input  sfdr_pkg::mem_wr_t              wr_i,
  output logic                           busy_o,
  output logic [sfdr_pkg::CELL_W-1:0]    rd_data_o
);

  localparam int unsigned AW = $clog2(MAX_CELLS);

  logic [sfdr_pkg::CELL_W-1:0] mem_q [MAX_CELLS];
  logic [sfdr_pkg::CELL_W-1:0] rd_q;
  logic [sfdr_pkg::CELL_W-1:0] fwd_data_q;
  logic                        fwd_q;
  logic                        clr_active_q;
  logic [AW-1:0]               clr_addr_q;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [sfdr_pkg::CELL_W-1:0] wdata;

  assign raddr = AW'(rd_index_i);
  assign we    = clr_active_q || wr_i.en;
  assign waddr = clr_active_q ? clr_addr_q : AW'(wr_i.index);
  assign wdata = clr_active_q ? sfdr_pkg::WORD_NEVER_SET : wr_i.data;

  // Sweep every entry to the never-set word once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      fwd_q        <= 1'b0;
    end else begin
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(MAX_CELLS - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (rd_en_i) begin
        fwd_q <= wr_i.en && (AW'(wr_i.index) == raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[raddr];
      fwd_data_q <= wr_i.data;
    end
  end

  // The array read sees the old word when a write hits the same edge
  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;
  assign busy_o    = clr_active_q;

endmodule

/* rtl/sfdr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sfdr_cfg_regs
// APB-style register port holding the cells_in_use register.
// ----------------------------------------------------------------------------
module sfdr_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfdr_pkg::PADDR_W-1:0]    paddr,
  input  logic [sfdr_pkg::PDATA_W-1:0]    pwdata,
  output logic [sfdr_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output logic [sfdr_pkg::CFG_W-1:0]      cells_in_use_o
);

  logic [sfdr_pkg::CFG_W-1:0] cells_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == sfdr_pkg::REG_CELLS_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= sfdr_pkg::CELLS_IN_USE_RST;
    end else if (wr_en) begin
      cells_q <= pwdata[sfdr_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      sfdr_pkg::REG_CELLS_IN_USE: prdata = sfdr_pkg::PDATA_W'(cells_q);
      default:                    prdata = '0;
    endcase
  end

  assign cells_in_use_o = cells_q;

endmodule

/* rtl/sfdr_record_unit.sv */
// ----------------------------------------------------------------------------
// sfdr_record_unit
// Compare stage and output register: checks each item against its previous
// word, writes changes back, keeps the time and frame state and issues
// change records.
// ----------------------------------------------------------------------------
module sfdr_record_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  sfdr_pkg::func_e                    func_i,
  input  logic [sfdr_pkg::IDX_W-1:0]         cell_index_i,
  input  logic [sfdr_pkg::CELL_W-1:0]        cell_value_i,
  input  logic [sfdr_pkg::CELL_W-1:0]        frame_delay_i,
  input  logic [sfdr_pkg::CELL_W-1:0]        prev_cell_i,
  input  logic [sfdr_pkg::CFG_W-1:0]         cells_in_use_i,
  output logic                               stage_ready_o,
  output sfdr_pkg::mem_wr_t                  wr_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sfdr_pkg::FRAME_W-1:0]       record_frame_o,
  output logic [sfdr_pkg::REC_IDX_W-1:0]     record_index_o,
  output logic [sfdr_pkg::CELL_W-1:0]        record_value_o,
  output logic                               record_last_o
);

  localparam int unsigned CW = sfdr_pkg::CELL_W;

  logic                              s1_valid_q;
  sfdr_pkg::func_e                   s1_func_q;
  logic [sfdr_pkg::IDX_W-1:0]        s1_index_q;
  logic [CW-1:0]                     s1_value_q;

  logic [sfdr_pkg::TIME_W-1:0]       elapsed_q;
  logic [CW-1:0]                     prev_hi_q;
  logic [CW-1:0]                     prev_lo_q;
  logic [sfdr_pkg::FRAME_W-1:0]      frame_q;

  logic                              out_valid_q;
  logic [sfdr_pkg::FRAME_W-1:0]      out_frame_q;
  logic [sfdr_pkg::REC_IDX_W-1:0]    out_index_q;
  logic [CW-1:0]                     out_value_q;
  logic                              out_last_q;

  logic                              out_free;
  logic                              cell_diff;
  logic                              hi_diff;
  logic                              lo_diff;
  logic [CW-1:0]                     time_hi;
  logic [CW-1:0]                     time_lo;
  logic                              retire;
  logic                              emit;
  logic                              hi_wr;
  logic                              lo_wr;
  logic [sfdr_pkg::REC_IDX_W-1:0]    rec_index;
  logic [CW-1:0]                     rec_value;
  logic                              rec_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign cell_diff = prev_cell_i != s1_value_q;
  assign time_hi   = elapsed_q[sfdr_pkg::TIME_W-1:CW];
  assign time_lo   = elapsed_q[CW-1:0];
  assign hi_diff   = prev_hi_q != time_hi;
  assign lo_diff   = prev_lo_q != time_lo;

  always_comb begin
    retire    = 1'b0;
    emit      = 1'b0;
    hi_wr     = 1'b0;
    lo_wr     = 1'b0;
    rec_index = '0;
    rec_value = '0;
    rec_last  = 1'b0;
    wr_o      = '0;
    if (s1_valid_q) begin
      unique case (s1_func_q)
        sfdr_pkg::FUNC_CELL: begin
          if (!cell_diff) begin
            retire = 1'b1;
          end else if (out_free) begin
            emit       = 1'b1;
            rec_index  = sfdr_pkg::REC_IDX_W'(s1_index_q);
            rec_value  = s1_value_q;
            rec_last   = 1'b1;
            wr_o.en    = 1'b1;
            wr_o.index = s1_index_q;
            wr_o.data  = s1_value_q;
            retire     = 1'b1;
          end
        end
        sfdr_pkg::FUNC_EOF: begin
          // High word first; once stored it no longer differs
          if (hi_diff) begin
            if (out_free) begin
              emit      = 1'b1;
              hi_wr     = 1'b1;
              rec_index = cells_in_use_i;
              rec_value = time_hi;
              rec_last  = !lo_diff;
              retire    = !lo_diff;
            end
          end else if (lo_diff) begin
            if (out_free) begin
              emit      = 1'b1;
              lo_wr     = 1'b1;
              rec_index = cells_in_use_i + 1'b1;
              rec_value = time_lo;
              rec_last  = 1'b1;
              retire    = 1'b1;
            end
          end else begin
            retire = 1'b1;
          end
        end
      endcase
    end
  end

  assign stage_ready_o = !s1_valid_q || retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_func_q   <= sfdr_pkg::FUNC_CELL;
      elapsed_q   <= '0;
      prev_hi_q   <= sfdr_pkg::WORD_NEVER_SET;
      prev_lo_q   <= sfdr_pkg::WORD_NEVER_SET;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
        s1_func_q  <= func_i;
        if (func_i == sfdr_pkg::FUNC_EOF) begin
          elapsed_q <= elapsed_q + sfdr_pkg::TIME_W'(frame_delay_i);
        end
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (hi_wr) begin
        prev_hi_q <= time_hi;
      end
      if (lo_wr) begin
        prev_lo_q <= time_lo;
      end
      if (retire && (s1_func_q == sfdr_pkg::FUNC_EOF)) begin
        frame_q <= frame_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_index_q <= cell_index_i;
      s1_value_q <= cell_value_i;
    end
    if (emit) begin
      out_frame_q <= frame_q;
      out_index_q <= rec_index;
      out_value_q <= rec_value;
      out_last_q  <= rec_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_frame_o = out_frame_q;
  assign record_index_o = out_index_q;
  assign record_value_o = out_value_q;
  assign record_last_o  = out_last_q;

endmodule

/* rtl/screen_frame_delta_recorder.sv */
// ----------------------------------------------------------------------------
// screen_frame_delta_recorder
// Turns a stream of screen cell words and end-of-frame marks into change
// records (frame, index, value, last).
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): func_i selects a cell word
// (cell_index_i, cell_value_i) or an end of frame (frame_delay_i). Cells at
// or beyond cells_in_use or MAX_CELLS are dropped without a record.
// Output channel (out_valid_o / out_ready_i): one record per changed word;
// record_last_o marks the final record of the item that caused it.
// A record passes from the compare stage register into the output register;
// the second record of an end of frame follows the first from the same stage.
// Throughput: one item per cycle while records can leave; an end of frame
// whose time high and low words both change holds the stage for both records.
// The compare stage issues at most one record per cycle into a single output
// register; the previous-value memory gives one read and one write a cycle.
// Reset: the previous-value memory is swept to all ones, one entry a cycle;
// in_ready_o stays low until the sweep ends. Register writes are taken
// during the sweep. Elapsed time and frame number clear.
// Stall: while out_ready_i is low, a finished record holds in the output
// register, one more item can wait in the compare stage, then in_ready_o
// drops.
// ----------------------------------------------------------------------------
module screen_frame_delta_recorder #(
  parameter int unsigned MAX_CELLS = sfdr_pkg::MAX_CELLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfdr_pkg::PADDR_W-1:0]      paddr,
  input  logic [sfdr_pkg::PDATA_W-1:0]      pwdata,
  output logic [sfdr_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [sfdr_pkg::IDX_W-1:0]        cell_index_i,
  input  logic [sfdr_pkg::CELL_W-1:0]       cell_value_i,
  input  logic [sfdr_pkg::CELL_W-1:0]       frame_delay_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sfdr_pkg::FRAME_W-1:0]      record_frame_o,
  output logic [sfdr_pkg::REC_IDX_W-1:0]    record_index_o,
  output logic [sfdr_pkg::CELL_W-1:0]       record_value_o,
  output logic                              record_last_o
);

  logic [sfdr_pkg::CFG_W-1:0]  cells_in_use;
  logic                        mem_busy;
  logic                        stage_ready;
  logic                        accept;
  logic                        in_range;
  logic                        is_eof;
  logic                        load;
  logic                        rd_en;
  logic [sfdr_pkg::CELL_W-1:0] prev_cell;
  sfdr_pkg::mem_wr_t           mem_wr;
  sfdr_pkg::func_e             func;

  sfdr_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cells_in_use_o (cells_in_use)
  );

  assign func       = sfdr_pkg::func_e'(func_i);
  assign is_eof     = func == sfdr_pkg::FUNC_EOF;
  assign in_ready_o = !mem_busy && stage_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (32'(cell_index_i) < 32'(MAX_CELLS)) &&
                      (sfdr_pkg::CFG_W'(cell_index_i) < cells_in_use);
  // Drop out-of-range cells at the transfer
  assign load       = accept && (is_eof || in_range);
  assign rd_en      = load && !is_eof;

  sfdr_cell_mem #(
    .MAX_CELLS (MAX_CELLS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_index_i (cell_index_i),
    .wr_i       (mem_wr),
    .busy_o     (mem_busy),
    .rd_data_o  (prev_cell)
  );

  sfdr_record_unit u_rec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .func_i         (func),
    .cell_index_i   (cell_index_i),
    .cell_value_i   (cell_value_i),
    .frame_delay_i  (frame_delay_i),
    .prev_cell_i    (prev_cell),
    .cells_in_use_i (cells_in_use),
    .stage_ready_o  (stage_ready),
    .wr_o           (mem_wr),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .record_frame_o (record_frame_o),
    .record_index_o (record_index_o),
    .record_value_o (record_value_o),
    .record_last_o  (record_last_o)
  );

endmodule
